// ===== hdl/sisr_pkg.sv =====
// Package with the shared types and constants of the stable insertion sort block.
`default_nettype none

package sisr_pkg;

	localparam int MAX_RECORDS_DEF = 64;
	localparam int KEY_W = 16;
	localparam int TAG_W = 32;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} rec_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_PREP,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// ===== hdl/sisr_store.sv =====
// Record store: one write port and one read port with registered read data.
`default_nettype none

module sisr_store
	import sisr_pkg::*;
#(
	parameter int MAX_RECORDS = MAX_RECORDS_DEF,
	localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire rec_t          wdata,
	input  wire logic [AW-1:0] raddr,
	output rec_t               rdata
);

	rec_t mem [MAX_RECORDS];
	rec_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/stable_insertion_sort_records.sv =====
// Top level of the stable insertion sort of keyed records.
//
// Channel  Direction  Handshake            Beat contents
// command  in         start && !busy       sort_key, record_tag, is_last
// result   out        out_valid, one cycle out_key, out_tag, out_last, overflow
//
// An insertion into an empty store writes the record directly; otherwise entries are moved up
// one at a time until the insertion point is found, since the store has a single read and write port.
// A record that finds the store full is dropped and sets the overflow flag.
// After the last record, a set-up state is followed by one beat per stored record.
// Reset clears the count, the overflow flag and the sequencer, not the store.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
`default_nettype none

module stable_insertion_sort_records
	import sisr_pkg::*;
#(
	parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic [KEY_W-1:0] sort_key,
	input  wire logic [TAG_W-1:0] record_tag,
	input  wire logic             is_last,
	output logic                  out_valid,
	output logic [KEY_W-1:0]      out_key,
	output logic [TAG_W-1:0]      out_tag,
	output logic                  out_last,
	output logic                  overflow
);

	localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int CW = $clog2(MAX_RECORDS + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_RECORDS);

	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic dropped_q, dropped_d;
	logic last_q, last_d;
	logic [AW-1:0] pos_q, pos_d;
	logic [AW-1:0] idx_q, idx_d;
	rec_t new_q, new_d;

	logic we;
	logic [AW-1:0] waddr;
	rec_t wdata;
	logic [AW-1:0] raddr;
	rec_t rdata;
	logic accept;
	logic move_up;

	sisr_store #(
		.MAX_RECORDS(MAX_RECORDS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign accept = start && (state_q == ST_IDLE);
	assign move_up = (pos_q != '0) && (rdata.key > new_q.key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			dropped_q <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			dropped_q <= dropped_d;
			last_q    <= last_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		idx_q <= idx_d;
		new_q <= new_d;
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		dropped_d = dropped_q;
		last_d    = last_q;
		pos_d     = pos_q;
		idx_d     = idx_q;
		new_d     = new_q;
		we        = 1'b0;
		waddr     = pos_q;
		wdata     = new_q;
		raddr     = pos_q - AW'(2);
		out_valid = 1'b0;
		out_last  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				raddr = AW'(count_q - CW'(1));
				if (accept) begin
					last_d = is_last;
					new_d  = '{key: sort_key, tag: record_tag};
					pos_d  = AW'(count_q);
					if (count_q == FULL) begin
						dropped_d = 1'b1;
						state_d   = is_last ? ST_PREP : ST_IDLE;
					end else if (count_q == '0) begin
						we      = 1'b1;
						waddr   = '0;
						wdata   = '{key: sort_key, tag: record_tag};
						count_d = CW'(1);
						state_d = is_last ? ST_PREP : ST_IDLE;
					end else begin
						state_d = ST_SHIFT;
					end
				end
			end
			ST_SHIFT: begin
				we = 1'b1;
				if (move_up) begin
					wdata = rdata;
					pos_d = pos_q - AW'(1);
				end else begin
					count_d = count_q + CW'(1);
					state_d = last_q ? ST_PREP : ST_IDLE;
				end
			end
			ST_PREP: begin
				raddr   = '0;
				idx_d   = '0;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				raddr     = idx_q + AW'(1);
				idx_d     = idx_q + AW'(1);
				if (CW'(idx_q) == count_q - CW'(1)) begin
					out_last  = 1'b1;
					count_d   = '0;
					dropped_d = 1'b0;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy     = (state_q != ST_IDLE);
	assign out_key  = rdata.key;
	assign out_tag  = rdata.tag;
	assign overflow = dropped_q;

	// A run is only emitted when the store holds at least one record.
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count_q != '0))
		else $error("result beat with an empty store");

	// The insertion point never lies beyond the current fill.
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (CW'(pos_q) <= count_q) && (count_q < FULL))
		else $error("insertion point beyond fill");

	// The final beat of a run returns the block to idle with a cleared set.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_last) |=> (!busy && (count_q == '0) && !overflow))
		else $error("set not cleared after final beat");

	// A record offered to a full store raises the overflow flag.
	a_drop_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (count_q == FULL)) |=> overflow)
		else $error("dropped record not flagged");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for the stable insertion sort of keyed records.
`timescale 1ns / 100ps

module tb_top;
	import sisr_pkg::*;

	localparam int CAPACITY = MAX_RECORDS_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = CAPACITY + 8;
	localparam int MAX_GAP = 12;
	localparam int DIRECTED_ROWS = 17;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic             last;
		logic             ovf;
	} sorted_beat_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic             last;
		logic             fixed;
		sorted_beat_t     want;
	} stim_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [KEY_W-1:0] sort_key = '0;
	logic [TAG_W-1:0] record_tag = '0;
	logic             is_last = 1'b0;
	logic             busy;
	logic             out_valid;
	logic [KEY_W-1:0] out_key;
	logic [TAG_W-1:0] out_tag;
	logic             out_last;
	logic             overflow;

	rec_t         sorted_store [CAPACITY];
	int           held_count = 0;
	bit           lost_flag = 1'b0;
	sorted_beat_t pending_beats [$];

	int mismatch_count = 0;
	int records_sent = 0;
	int sets_sent = 0;
	int sets_overflowed = 0;
	int beats_checked = 0;
	int quiet_cycles = 0;

	// Single-record sets, two of them at the key extremes, have their sorted beat written out by hand.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{16'h0000, 32'h0000_0000, 1'b1, 1'b1, '{16'h0000, 32'h0000_0000, 1'b1, 1'b0}},
		'{16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, '{16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0}},
		'{16'h1234, 32'hA5A5_A5A5, 1'b1, 1'b1, '{16'h1234, 32'hA5A5_A5A5, 1'b1, 1'b0}},
		'{16'h0005, 32'h0000_0001, 1'b0, 1'b0, '0},
		'{16'h0003, 32'h0000_0002, 1'b0, 1'b0, '0},
		'{16'h0005, 32'h0000_0003, 1'b0, 1'b0, '0},
		'{16'h0003, 32'h0000_0004, 1'b0, 1'b0, '0},
		'{16'hFFFF, 32'h0000_0005, 1'b0, 1'b0, '0},
		'{16'h0000, 32'h0000_0006, 1'b1, 1'b0, '0},
		'{16'h0040, 32'h5A5A_5A5A, 1'b0, 1'b0, '0},
		'{16'h0030, 32'hFFFF_0000, 1'b0, 1'b0, '0},
		'{16'h0020, 32'h0000_FFFF, 1'b0, 1'b0, '0},
		'{16'h0010, 32'h8000_0001, 1'b0, 1'b0, '0},
		'{16'h0000, 32'hFFFF_FFFF, 1'b1, 1'b0, '0},
		'{16'h0007, 32'h0000_000A, 1'b0, 1'b0, '0},
		'{16'h0007, 32'h0000_000B, 1'b0, 1'b0, '0},
		'{16'h0007, 32'h0000_000C, 1'b1, 1'b0, '0}
	};

	always #6 clk = ~clk;

	stable_insertion_sort_records #(.MAX_RECORDS(CAPACITY)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sort_key(sort_key),
		.record_tag(record_tag),
		.is_last(is_last),
		.out_valid(out_valid),
		.out_key(out_key),
		.out_tag(out_tag),
		.out_last(out_last),
		.overflow(overflow)
	);

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// Places one record at its stable position, or marks it lost when the model is full, and,
	// on the final record of a set, queues the whole sorted run or the hand-written beat.
	task automatic insert_and_emit(input rec_t rec, input logic last, input bit fixed,
			input sorted_beat_t want);
		int pos;
		if (held_count < CAPACITY) begin
			pos = held_count;
			while (pos > 0 && sorted_store[pos-1].key > rec.key) begin
				sorted_store[pos] = sorted_store[pos-1];
				pos--;
			end
			sorted_store[pos] = rec;
			held_count++;
		end else begin
			lost_flag = 1'b1;
		end
		if (last) begin
			if (lost_flag)
				sets_overflowed++;
			if (fixed) begin
				pending_beats.push_back(want);
			end else begin
				for (int i = 0; i < held_count; i++)
					pending_beats.push_back('{sorted_store[i].key, sorted_store[i].tag,
						i == held_count - 1, lost_flag});
			end
			held_count = 0;
			lost_flag = 1'b0;
			sets_sent++;
		end
	endtask

	task automatic send_record(input rec_t rec, input logic last, input int idle_pct,
			input bit fixed, input sorted_beat_t want);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		sort_key <= rec.key;
		record_tag <= rec.tag;
		is_last <= last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		insert_and_emit(rec, last, fixed, want);
		records_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(3))
			0, 1: return KEY_W'($urandom_range(7));
			2: return $urandom_range(1) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
			default: return KEY_W'($urandom);
		endcase
	endfunction

	task automatic send_set(input int size, input int idle_pct);
		rec_t rec;
		for (int n = 1; n <= size; n++) begin
			rec.key = pick_key();
			rec.tag = $urandom;
			send_record(rec, n == size, idle_pct, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		sorted_beat_t want;
		if (arst_n && out_valid) begin
			if (pending_beats.size() == 0) begin
				report_mismatch($sformatf("unexpected beat key %h tag %h", out_key, out_tag));
			end else begin
				want = pending_beats.pop_front();
				beats_checked++;
				if (out_key !== want.key)
					report_mismatch($sformatf("out_key %h, wanted %h", out_key, want.key));
				if (out_tag !== want.tag)
					report_mismatch($sformatf("out_tag %h, wanted %h", out_tag, want.tag));
				if (out_last !== want.last)
					report_mismatch($sformatf("out_last %b, wanted %b", out_last, want.last));
				if (overflow !== want.ovf)
					report_mismatch($sformatf("overflow %b, wanted %b", overflow, want.ovf));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || out_valid)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no beat for %0d cycles, %0d results outstanding",
				STALL_LIMIT, pending_beats.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		rec_t rec;
		int   idle_pct;
		int   budget;
		int   size;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[r]) begin
			rec.key = directed_rows[r].key;
			rec.tag = directed_rows[r].tag;
			send_record(rec, directed_rows[r].last, 0, directed_rows[r].fixed,
				directed_rows[r].want);
		end
		drain_results();

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 0 : (phase == 1) ? 75 : 26;
			if (phase == 2)
				send_set(CAPACITY + 2, idle_pct);
			budget = 0;
			while (budget < 15) begin
				size = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 10);
				send_set(size, idle_pct);
				budget += size;
			end
			drain_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sorted %0d records in %0d sets, %0d of them past capacity; %0d beats checked.",
			records_sent, sets_sent, sets_overflowed, beats_checked);
		$display("Sets ranged from one record to beyond a full store, under three idle rates.");
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
